// ===== rtl/core/tbpq_pkg.sv =====
// tbpq_pkg: types and constants shared by the two-button press qualifier
// holds the beat structs, code enums and fixed defaults; no dependencies
package tbpq_pkg;

  // register indexes on the write port
  typedef enum logic [1:0] {
    REG_MIN_PRESS    = 2'd0,
    REG_RESET_HOLD   = 2'd1,
    REG_COOLDOWN_ONE = 2'd2,
    REG_COOLDOWN_TWO = 2'd3
  } reg_index_t;

  // system state as sampled on each tick
  typedef enum logic [1:0] {
    SYS_NORMAL  = 2'd0,
    SYS_BUSY    = 2'd1,
    SYS_WARNING = 2'd2,
    SYS_OTHER   = 2'd3
  } sys_state_t;

  // state change requested by the qualifier
  typedef enum logic [1:0] {
    REQ_NONE    = 2'd0,
    REQ_NORMAL  = 2'd1,
    REQ_WARNING = 2'd2,
    REQ_FACTORY = 2'd3
  } req_t;

  // wake-up button ids
  localparam logic [1:0] WAKE_ONE = 2'd1;
  localparam logic [1:0] WAKE_TWO = 2'd2;

  localparam int unsigned CFG_W   = 20;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned CLOCK_W = 32;

  // fixed timing defaults
  localparam logic [15:0] MIN_PRESS_DEFAULT  = 16'd200;
  localparam logic [19:0] RESET_HOLD_DEFAULT = 20'd8000;
  localparam logic [19:0] WARN_LEAD          = 20'd3000;
  localparam logic [15:0] COOLDOWN_DEFAULT   = 16'd2000;

  // input beat
  typedef struct packed {
    logic       level_one;
    logic       level_two;
    sys_state_t system_state;
    logic [1:0] wakeup_button;
  } item_t;

  // result beat
  typedef struct packed {
    logic fire_one;
    logic fire_two;
    req_t state_request;
    logic cooldown_block;
  } result_t;

  // configuration register set
  typedef struct packed {
    logic [15:0] min_press_ms;
    logic [19:0] reset_hold_ms;
    logic [15:0] cooldown_one_ms;
    logic [15:0] cooldown_two_ms;
  } cfg_t;

endpackage

// ===== rtl/core/tbpq_cfg.sv =====
// tbpq_cfg: configuration register bank of the press qualifier
// depends on tbpq_pkg for the register indexes and the cfg_t struct
module tbpq_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tbpq_pkg::CFG_W-1:0]  cfg_data,
  output tbpq_pkg::cfg_t              cfg
);
  import tbpq_pkg::*;

  // register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_press_ms    <= MIN_PRESS_DEFAULT;
      cfg.reset_hold_ms   <= RESET_HOLD_DEFAULT;
      cfg.cooldown_one_ms <= COOLDOWN_DEFAULT;
      cfg.cooldown_two_ms <= COOLDOWN_DEFAULT;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MIN_PRESS:    cfg.min_press_ms    <= cfg_data[15:0];
        REG_RESET_HOLD:   cfg.reset_hold_ms   <= cfg_data[19:0];
        REG_COOLDOWN_ONE: cfg.cooldown_one_ms <= cfg_data[15:0];
        REG_COOLDOWN_TWO: cfg.cooldown_two_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/tbpq_core.sv =====
// tbpq_core: press timing, both-held reset and cooldown state for one tick
// depends on tbpq_pkg; result is combinational, state moves on step
module tbpq_core #(
  parameter int unsigned POLL_PERIOD_MS = 50
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tbpq_pkg::item_t   item,
  input  tbpq_pkg::cfg_t    cfg,
  output tbpq_pkg::result_t result
);
  import tbpq_pkg::*;

  localparam logic [TIME_W:0]  STEP_T = (TIME_W+1)'(POLL_PERIOD_MS);
  localparam logic [CLOCK_W:0] STEP_C = (CLOCK_W+1)'(POLL_PERIOD_MS);

  logic               prev_one, prev_one_next;
  logic               prev_two, prev_two_next;
  logic [TIME_W-1:0]  press_one_ms, press_one_ms_next;
  logic [TIME_W-1:0]  press_two_ms, press_two_ms_next;
  logic               chord_on, chord_on_next;
  logic [TIME_W-1:0]  both_ms, both_ms_next;
  logic [CLOCK_W-1:0] clock_ms, clock_ms_next;
  logic [CLOCK_W-1:0] last_one_ms, last_one_ms_next;
  logic [CLOCK_W-1:0] last_two_ms, last_two_ms_next;
  logic               halted, halted_next;

  logic               b1, b2, both_now;
  logic [TIME_W-1:0]  rt, wt, both_base;
  logic [TIME_W:0]    both_sum, press_one_sum, press_two_sum;
  logic [TIME_W-1:0]  both_inc;
  logic [CLOCK_W:0]   clock_sum;
  logic [15:0]        minp;
  logic               rel_one, rel_two, qual_one, qual_two, cd_one, cd_two;
  result_t            res;

  assign b1       = item.level_one;
  assign b2       = item.level_two;
  assign both_now = !b1 && !b2;

  // reset and warning thresholds from the live register
  assign rt   = (cfg.reset_hold_ms == '0) ? RESET_HOLD_DEFAULT : cfg.reset_hold_ms;
  assign wt   = (rt > WARN_LEAD) ? rt - WARN_LEAD : {1'b0, rt[TIME_W-1:1]};
  assign minp = (cfg.min_press_ms == '0) ? MIN_PRESS_DEFAULT : cfg.min_press_ms;

  // saturating adds for the both-held timer, press timers and clock
  assign both_base     = chord_on ? both_ms : '0;
  assign both_sum      = {1'b0, both_base} + STEP_T;
  assign both_inc      = both_sum[TIME_W] ? '1 : both_sum[TIME_W-1:0];
  assign press_one_sum = {1'b0, press_one_ms} + STEP_T;
  assign press_two_sum = {1'b0, press_two_ms} + STEP_T;
  assign clock_sum     = {1'b0, clock_ms} + STEP_C;

  // release qualification per button
  assign rel_one  = !prev_one && b1 && b2;
  assign rel_two  = !prev_two && b1 && b2;
  assign qual_one = (item.wakeup_button != WAKE_ONE) && (press_one_ms >= TIME_W'(minp))
                    && (item.system_state == SYS_NORMAL);
  assign qual_two = (item.wakeup_button != WAKE_TWO) && (press_two_ms >= TIME_W'(minp))
                    && (item.system_state == SYS_NORMAL);
  assign cd_one   = (clock_ms - last_one_ms) < CLOCK_W'(cfg.cooldown_one_ms);
  assign cd_two   = (clock_ms - last_two_ms) < CLOCK_W'(cfg.cooldown_two_ms);

  // next state and result for the current tick
  always_comb begin
    prev_one_next     = b1;
    prev_two_next     = b2;
    press_one_ms_next = press_one_ms;
    press_two_ms_next = press_two_ms;
    chord_on_next     = chord_on;
    both_ms_next      = both_ms;
    last_one_ms_next  = last_one_ms;
    last_two_ms_next  = last_two_ms;
    halted_next       = 1'b0;
    res               = '0;
    res.state_request = REQ_NONE;
    if (both_now) begin
      chord_on_next = 1'b1;
      both_ms_next  = both_inc;
      if (both_inc > rt) begin
        res.state_request = REQ_FACTORY;
        halted_next       = 1'b1;
      end else if (both_inc > wt && item.system_state != SYS_WARNING) begin
        res.state_request = REQ_WARNING;
      end
    end else begin
      if (chord_on) begin
        chord_on_next = 1'b0;
        both_ms_next  = '0;
        if (item.system_state == SYS_WARNING) begin
          res.state_request = REQ_NORMAL;
        end
      end
      if (rel_one) begin
        press_one_ms_next = '0;
        if (qual_one) begin
          if (cd_one) begin
            res.cooldown_block = 1'b1;
          end else begin
            res.fire_one     = 1'b1;
            last_one_ms_next = clock_ms;
          end
        end
      end
      if (rel_two) begin
        press_two_ms_next = '0;
        if (qual_two) begin
          if (cd_two) begin
            res.cooldown_block = 1'b1;
          end else begin
            res.fire_two     = 1'b1;
            last_two_ms_next = clock_ms;
          end
        end
      end
      if (!b1 && b2) begin
        press_one_ms_next = press_one_sum[TIME_W] ? '1 : press_one_sum[TIME_W-1:0];
      end
      if (!b2 && b1) begin
        press_two_ms_next = press_two_sum[TIME_W] ? '1 : press_two_sum[TIME_W-1:0];
      end
    end
    if (halted_next) begin
      clock_ms_next = clock_ms;
    end else begin
      clock_ms_next = clock_sum[CLOCK_W] ? '1 : clock_sum[CLOCK_W-1:0];
    end
  end

  // halted block answers all zero
  always_comb begin
    if (halted) begin
      result               = '0;
      result.state_request = REQ_NONE;
    end else begin
      result = res;
    end
  end

  // state registers, frozen once halted
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_one     <= 1'b1;
      prev_two     <= 1'b1;
      press_one_ms <= '0;
      press_two_ms <= '0;
      chord_on     <= 1'b0;
      both_ms      <= '0;
      clock_ms     <= '0;
      last_one_ms  <= '0;
      last_two_ms  <= '0;
      halted       <= 1'b0;
    end else if (step && !halted) begin
      prev_one     <= prev_one_next;
      prev_two     <= prev_two_next;
      press_one_ms <= press_one_ms_next;
      press_two_ms <= press_two_ms_next;
      chord_on     <= chord_on_next;
      both_ms      <= both_ms_next;
      clock_ms     <= clock_ms_next;
      last_one_ms  <= last_one_ms_next;
      last_two_ms  <= last_two_ms_next;
      halted       <= halted_next;
    end
  end

endmodule

// ===== rtl/core/two_button_press_qualifier.sv =====
// two_button_press_qualifier: top level, input register -> update -> result register
// a beat taken into the input register moves on to the result register once that register can take it
// throughput: one beat per cycle; the input register advances whenever the
// result register is empty or being taken, so the rate is set by result_stall
// reset (rst, synchronous): configuration to defaults, all timers and the halt cleared
// depends on tbpq_pkg, tbpq_cfg and tbpq_core
module two_button_press_qualifier #(
  parameter int unsigned POLL_PERIOD_MS = 50
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  tbpq_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output tbpq_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [tbpq_pkg::CFG_W-1:0]  cfg_data
);
  import tbpq_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    out_free;
  logic    step;
  result_t core_result;

  // register bank
  tbpq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // handshake: the input register moves when the result register can take a beat
  assign out_free   = !result_valid || !result_stall;
  assign step       = item_q_valid && out_free;
  assign item_stall = item_q_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!item_stall) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      item_q <= item;
    end
  end

  // tick update
  tbpq_core #(
    .POLL_PERIOD_MS (POLL_PERIOD_MS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_result;
    end
  end

endmodule
